// ===== sv/drift_modulation_offsets_assert.svh =====
// Assertion macros for the drift modulation offsets block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DRIFT_MODULATION_OFFSETS_ASSERT_SVH
`define DRIFT_MODULATION_OFFSETS_ASSERT_SVH
`ifndef SYNTH
`define DMO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DMO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DMO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DMO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/dmo_pkg.sv =====
// Package for the drift modulation offsets block: word types, term constants,
// quarter-wave sine table function. No dependencies.
`timescale 1ns / 1ps
package dmo_pkg;
   localparam int SINE_TABLE_ADDR_BITS = 10;
   localparam int QTR_SIZE = 1 << SINE_TABLE_ADDR_BITS;
   localparam int NUM_OUT = 11;

   typedef struct packed {
      logic [31:0] phase;
      logic [15:0] contractivity;
      logic signed [15:0] zoom;
   } req_word_type;

   typedef struct packed {
      logic signed [23:0] zoom_delta;
      logic signed [23:0] rotate_delta;
      logic signed [23:0] pan_x_delta;
      logic signed [23:0] pan_y_delta;
      logic signed [23:0] hue_delta;
      logic signed [23:0] inject_x_delta;
      logic signed [23:0] inject_y_delta;
      logic signed [23:0] julia_x_delta;
      logic signed [23:0] julia_y_delta;
      logic signed [23:0] escape_x_delta;
      logic signed [23:0] escape_y_delta;
   } rsp_word_type;

   typedef logic [23:0] sine_mag_type;

   // Q1.16 frequency ratios
   localparam logic [16:0] RATIO [NUM_OUT] = '{
      17'd65536, 17'd47972, 17'd33882, 17'd20513, 17'd13828, 17'd27591,
      17'd18153, 17'd40042, 17'd25494, 17'd10289, 17'd7406};
   // Q0.20 scales
   localparam logic [19:0] SCALE [NUM_OUT] = '{
      20'd104858, 20'd838861, 20'd314573, 20'd314573, 20'd1573, 20'd471859,
      20'd471859, 20'd125829, 20'd125829, 20'd262144, 20'd262144};
   // bit i set: lane i uses the quarter-cycle shifted angle (pan_y, inject_y, julia_y, escape_y)
   localparam logic [NUM_OUT-1:0] IS_COSINE = 11'b10101001000;
   localparam logic [NUM_OUT-1:0] IS_CAMERA = 11'b00000001111;

   localparam logic [27:0] LOOP_CAP_Q28 = 28'd263066747;

   // Quarter-wave entry: Taylor sum in Q2.30, evaluated at elaboration or as logic.
   function automatic sine_mag_type sine_entry(input logic [SINE_TABLE_ADDR_BITS:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x = ({53'd0, k} * 64'd1686629713) >> SINE_TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      v = (sum + 64'd64) >> 7;
      if (v > 64'd8388607) v = 64'd8388607;
      return v[23:0];
   endfunction

   function automatic sine_mag_type [QTR_SIZE:0] build_table();
      sine_mag_type [QTR_SIZE:0] t;
      for (int k = 0; k <= QTR_SIZE; k++) begin
         t[k] = sine_entry((SINE_TABLE_ADDR_BITS+1)'(k));
      end
      return t;
   endfunction

   localparam sine_mag_type [QTR_SIZE:0] QUARTER_WAVE = build_table();
endpackage

// ===== sv/drift_modulation_offsets.sv =====
// Drift modulation offsets: eleven sine-driven offsets per input word.
// Throughput one word
// per cycle (four lane register stages, all on one enable; a stalled result holds the pipe).
// Synchronous active-high reset clears valid bits and depth_ff.
// Depends on dmo_pkg, dmo_lane and drift_modulation_offsets_assert.svh.
`timescale 1ns / 1ps
`include "drift_modulation_offsets_assert.svh"
module drift_modulation_offsets
   import dmo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [15:0]  csr_data
);
   localparam int STAGES = 4;
   logic [15:0] depth_ff;
   logic [STAGES-1:0] vld_ff, vld_in;
   logic advance;
   // whole pipe moves unless the output word is stalled
   assign advance = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   // compliance from contractivity*|zoom|, stage 0 combinational
   logic [15:0] zmag;
   logic [31:0] loop;
   logic [27:0] capped;
   logic [28:0] csum;
   logic [16:0] compl16_in, compl16_ff;
   assign zmag = req_word.zoom[15] ? 16'(-req_word.zoom) : req_word.zoom;
   assign loop = req_word.contractivity * zmag;
   assign capped = (loop > {4'd0, LOOP_CAP_Q28}) ? LOOP_CAP_Q28 : loop[27:0];
   assign csum = 29'h1000_0000 - {1'b0, capped} + 29'd2048;
   assign compl16_in = csum[28:12];

   logic [STAGES-1:0] zero_ff;
   logic [NUM_OUT-1:0][23:0] lane_res;

   always_ff @(posedge clock) begin
      if (reset) depth_ff <= '0;
      else if (csr_write) depth_ff <= csr_data;
   end
   assign vld_in = {vld_ff[STAGES-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end
   // compliance registered beside lane stage 1, read by lane stage 2
   always_ff @(posedge clock) begin
      if (advance) begin
         compl16_ff <= compl16_in;
         zero_ff    <= {zero_ff[STAGES-2:0], depth_ff == 16'd0};
      end
   end

   for (genvar g = 0; g < NUM_OUT; g++) begin : g_lane
      dmo_lane u_lane (
         .clock(clock), .advance(advance), .phase(req_word.phase),
         .ratio(RATIO[g]), .scale(SCALE[g]), .cosine(IS_COSINE[g]),
         .camera(IS_CAMERA[g]), .depth(depth_ff), .compl16(compl16_ff),
         .result(lane_res[g]));
   end

   // pack lanes; zero depth forces an all-zero word
   always_comb begin
      rsp_word = {lane_res[0], lane_res[1], lane_res[2], lane_res[3], lane_res[4],
                  lane_res[5], lane_res[6], lane_res[7], lane_res[8], lane_res[9],
                  lane_res[10]};
      if (zero_ff[STAGES-1]) rsp_word = '0;
   end
   assign rsp_valid = vld_ff[STAGES-1];

   `DMO_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `DMO_ASSERT_NEXT(a_stall_word, clock, reset, rsp_valid && rsp_stall, $stable(rsp_word))
   `DMO_ASSERT_IMPL(a_stall_in, clock, reset, rsp_valid && rsp_stall, req_stall)
   `DMO_ASSERT_NEXT(a_depth_hold, clock, reset, !csr_write, $stable(depth_ff))
endmodule

// ===== sv/dmo_lane.sv =====
// One offset lane: angle, sine lookup, amplitude products, rounding, clamp.
// Depends on dmo_pkg. Four register stages, advanced by a shared enable.
`timescale 1ns / 1ps
module dmo_lane
   import dmo_pkg::*;
(
   input  logic               clock,
   input  logic               advance,
   input  logic [31:0]        phase,
   input  logic [16:0]        ratio,
   input  logic [19:0]        scale,
   input  logic               cosine,
   input  logic               camera,
   input  logic [15:0]        depth,
   input  logic [16:0]        compl16,
   output logic signed [23:0] result
);
   // stage 1: angle and depth*scale
   logic [31:0] angle_in, angle_ff;
   logic [35:0] amp_in, amp_ff;
   logic [48:0] prod;
   assign prod = phase * ratio;
   assign angle_in = prod[31:0] + (cosine ? 32'h4000_0000 : 32'h0);
   assign amp_in = depth * scale;

   // stage 2: table read, compliance product
   sine_mag_type sine_in, sine_ff;
   logic neg_ff, neg2_ff;
   logic [SINE_TABLE_ADDR_BITS-1:0] off;
   logic [SINE_TABLE_ADDR_BITS:0] idx;
   logic [35:0] amp2_in, amp2_ff;
   logic [52:0] camp;
   assign off = angle_ff[29 -: SINE_TABLE_ADDR_BITS];
   assign idx = angle_ff[30] ? (QTR_SIZE[SINE_TABLE_ADDR_BITS:0] - {1'b0, off})
                             : {1'b0, off};
   assign sine_in = QUARTER_WAVE[idx];
   assign camp = amp_ff * compl16 + 53'd32768;
   assign amp2_in = camera ? camp[51:16] : amp_ff;

   // stage 3: amplitude times sine magnitude
   logic [59:0] mag_in, mag_ff;
   assign mag_in = amp2_ff * sine_ff;

   // stage 4: round, sign, clamp
   logic [24:0] rmag;
   logic [59:0] rnd;
   logic signed [23:0] res_in, res_ff;
   assign rnd = mag_ff + (60'd1 << 35);
   assign rmag = (rnd[59:36] > 24'd8388608 || rnd[59:60-1] != 1'b0) ? 25'd8388608
                 : {1'b0, rnd[59:36]};
   always_comb begin
      if (neg2_ff) res_in = -24'(rmag);
      else if (rmag > 25'd8388607) res_in = 24'sd8388607;
      else res_in = 24'(rmag);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
         amp_ff   <= amp_in;
         sine_ff  <= sine_in;
         neg_ff   <= angle_ff[31];
         amp2_ff  <= amp2_in;
         mag_ff   <= mag_in;
         neg2_ff  <= neg_ff;
         res_ff   <= res_in;
      end
   end
   assign result = res_ff;
endmodule

// ===== bench/tb_drift_modulation_offsets.sv =====
// Testbench for drift_modulation_offsets: drives phase/contractivity/zoom words,
// predicts the eleven offsets in fixed point and checks every result word.
// Depends on dmo_pkg (word types, sizes) and the block's RTL.
`timescale 1ns / 1ps
module tb_drift_modulation_offsets;
   import dmo_pkg::*;

   localparam int ADDR_BITS = SINE_TABLE_ADDR_BITS;
   localparam int RAND_WORDS = 1030;
   localparam int LATENCY = 4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write = 1'b0;
   logic [15:0]  csr_data = '0;

   drift_modulation_offsets dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Offset term constants: ratio Q1.16, scale Q0.20
   localparam int unsigned FREQ_RATIO [11] = '{65536, 47972, 33882, 20513, 13828, 27591,
      18153, 40042, 25494, 10289, 7406};
   localparam int unsigned DEPTH_SCALE [11] = '{104858, 838861, 314573, 314573, 1573,
      471859, 471859, 125829, 125829, 262144, 262144};
   localparam bit USES_COSINE [11] = '{0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1};
   localparam bit IS_CAM [11] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};

   logic [23:0]  qwave [0:(1<<ADDR_BITS)];
   logic [15:0]  depth_reg;
   rsp_word_type offsets_pending [$];
   int           fail_count = 0;
   int           words_checked = 0;
   int           depths_used = 0;
   int           stall_left = 0;

   // Quarter-wave table from a Taylor sum in Q2.30
   task automatic fill_qwave();
      longint unsigned x, x2, term, sum, v;
      for (int k = 0; k <= (1 << ADDR_BITS); k++) begin
         x = (longint'(k) * 64'd1686629713) >> ADDR_BITS;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         v = (sum + 64) >> 7;
         if (v > 8388607) v = 8388607;
         qwave[k] = v[23:0];
      end
   endtask

   function automatic rsp_word_type drift_offsets(req_word_type w, logic [15:0] depth);
      logic [23:0] lanes [11];
      rsp_word_type r;
      longint unsigned zmag, loopq, compl, amp, mag;
      logic [31:0] angle;
      logic [1:0] quad;
      int unsigned off, idx;
      zmag = w.zoom[15] ? (65536 - longint'(w.zoom[15:0])) : longint'(w.zoom[15:0]);
      loopq = longint'(w.contractivity) * zmag;
      if (loopq > 263066747) loopq = 263066747;
      compl = (268435456 - loopq + 2048) >> 12;
      for (int i = 0; i < 11; i++) begin
         angle = 32'(longint'(w.phase) * FREQ_RATIO[i]);
         if (USES_COSINE[i]) angle = angle + 32'h4000_0000;
         amp = longint'(depth) * DEPTH_SCALE[i];
         if (IS_CAM[i]) amp = (amp * compl + 32768) >> 16;
         quad = angle[31:30];
         off = (angle >> (30 - ADDR_BITS)) & ((1 << ADDR_BITS) - 1);
         idx = quad[0] ? (1 << ADDR_BITS) - off : off;
         mag = (amp * qwave[idx] + (64'd1 << 35)) >> 36;
         if (quad[1]) begin
            if (mag > 8388608) mag = 8388608;
            lanes[i] = -mag[23:0];
         end else begin
            if (mag > 8388607) mag = 8388607;
            lanes[i] = mag[23:0];
         end
         if (depth == 0) lanes[i] = '0;
      end
      r = {lanes[0], lanes[1], lanes[2], lanes[3], lanes[4], lanes[5], lanes[6],
           lanes[7], lanes[8], lanes[9], lanes[10]};
      return r;
   endfunction

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Directed table: phase, contractivity, zoom
   typedef struct {
      logic [31:0] phase;
      logic [15:0] contractivity;
      logic [15:0] zoom;
   } dir_row_type;

   // valid stays high into the next word when there is no gap
   task automatic send_word(req_word_type w);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      offsets_pending.push_back(drift_offsets(w, depth_reg));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_depth(logic [15:0] d);
      req_valid <= 1'b0;
      while (offsets_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= d;
      depth_reg = d;
      @(posedge clock);
      csr_write <= 1'b0;
      depths_used++;
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (offsets_pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            fail_count++;
         end else begin
            want = offsets_pending.pop_front();
            words_checked++;
            if (rsp_word !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_word);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls: mostly single cycles, now and then a long run
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
         stall_left = idle_len();
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   initial begin
      #50_000_000;
      $display("drift_modulation_offsets verification failed");
      $finish;
   end

   initial begin
      dir_row_type dir_rows [9] = '{
         '{32'h0000_0000, 16'h0000, 16'h0000},
         '{32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF},
         '{32'h0000_4000, 16'h4000, 16'h8000},
         '{32'h0000_8000, 16'h4000, 16'h4000},
         '{32'h0000_C000, 16'h2000, 16'hC000},
         '{32'h8000_0000, 16'hFFFF, 16'h8000},
         '{32'h0001_2345, 16'h0001, 16'hFFFF},
         '{32'h5555_AAAA, 16'h1234, 16'h0001},
         '{32'hAAAA_5555, 16'h3E00, 16'h4000}
      };
      logic [15:0] depth_set [3] = '{16'hFFFF, 16'h0001, 16'h8000};
      req_word_type w;
      fill_qwave();
      depth_reg = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero depth after reset: all offsets zero
      foreach (dir_rows[i]) begin
         w = '{dir_rows[i].phase, dir_rows[i].contractivity, dir_rows[i].zoom};
         send_word(w);
         if (drift_offsets(w, depth_reg) !== '0) begin
            $display("%0t: mismatch expected %h actual %h", $time, rsp_word_type'('0),
                     drift_offsets(w, depth_reg));
            fail_count++;
         end
      end
      foreach (depth_set[d]) begin
         set_depth(depth_set[d]);
         foreach (dir_rows[i]) begin
            if (d == 2 && i > 3) break;
            send_word('{dir_rows[i].phase, dir_rows[i].contractivity, dir_rows[i].zoom});
         end
      end

      // Random phases with varying depth, including zero and full scale
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n % 150 == 0) begin
            case ((n / 150) % 4)
               0: set_depth(16'(($urandom_range(1, 65535))));
               1: set_depth(16'hFFFF);
               2: set_depth(16'h0000);
               default: set_depth(16'($urandom_range(1, 255)));
            endcase
         end
         w.phase = $urandom();
         w.contractivity = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 16384));
         w.zoom = 16'($urandom());
         send_word(w);
      end
      req_valid <= 1'b0;

      repeat (2000) begin
         if (offsets_pending.size() == 0) break;
         @(posedge clock);
      end
      repeat (LATENCY + 5) @(posedge clock);
      $display("Checked %0d result words over %0d depth settings.", words_checked, depths_used);
      if (fail_count == 0 && offsets_pending.size() == 0)
         $display("drift_modulation_offsets verification clean");
      else
         $display("drift_modulation_offsets verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+sv
sv/dmo_pkg.sv
sv/dmo_lane.sv
sv/drift_modulation_offsets.sv
bench/tb_drift_modulation_offsets.sv
